[rtl/lfaa_pkg.sv]
`timescale 1ns / 1ps
package lfaa_pkg;

  localparam int ENTRY_BITS   = 16;
  localparam int CORDIC_W     = 32;
  localparam int Q_W          = 18;
  localparam int NORM_TOP     = 29;
  localparam int PI_Q12       = 12868;
  localparam int HALF_PI_Q12  = 6434;
  localparam int INV_GAIN_Q30 = 652032874;
  localparam int INV_GAIN_W   = 30;
  localparam int TABLE_LEN    = 24;

  // atan(2^-i) in Q30
  localparam longint ATAN_Q30 [0:TABLE_LEN-1] = '{
    843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
    16775851, 8388437, 4194283, 2097149, 1048576, 524288,
    262144, 131072, 65536, 32768, 16384, 8192,
    4096, 2048, 1024, 512, 256, 128
  };

  // flags that ride along the yaw chain
  typedef struct packed {
    logic need;
    logic z_zero;
    logic z_neg;
    logic x_pos;
    logic x_neg;
  } yaw_flags_t;

  // table angle rounded to nearest into the accumulator format
  function automatic int atan_step(input int i, input int frac);
    longint half;
    begin
      half = longint'(1) << (29 - frac);
      return int'((ATAN_Q30[i] + half) >>> (30 - frac));
    end
  endfunction

endpackage

[rtl/lfaa_cordic_cell.sv]
`timescale 1ns / 1ps
module lfaa_cordic_cell #(
  parameter int IDX = 0,
  parameter int AW  = 16,
  parameter int DW  = 32,
  parameter int TW  = 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic signed [DW-1:0] in_x,
  input  logic signed [DW-1:0] in_y,
  input  logic signed [AW-1:0] in_a,
  input  logic                 in_zero,
  input  logic [TW-1:0]        in_tag,
  output logic                 out_valid,
  output logic signed [DW-1:0] out_x,
  output logic signed [DW-1:0] out_y,
  output logic signed [AW-1:0] out_a,
  output logic                 out_zero,
  output logic [TW-1:0]        out_tag
);
  import lfaa_pkg::*;

  localparam logic signed [AW-1:0] STEP = AW'(atan_step(IDX, AW - 4));

  logic signed [DW-1:0] dx, dy;

  assign dx = in_y >>> IDX;
  assign dy = in_x >>> IDX;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  // rotate toward y = 0
  always_ff @(posedge clk) begin
    if (in_valid) begin
      if (!in_y[DW-1]) begin
        out_x <= in_x + dx;
        out_y <= in_y - dy;
        out_a <= in_a + STEP;
      end else begin
        out_x <= in_x - dx;
        out_y <= in_y + dy;
        out_a <= in_a - STEP;
      end
      out_zero <= in_zero;
      out_tag  <= in_tag;
    end
  end

endmodule

[rtl/lfaa_cordic_chain.sv]
`timescale 1ns / 1ps
module lfaa_cordic_chain #(
  parameter int STAGES = 14,
  parameter int AW     = 16,
  parameter int DW     = 32,
  parameter int TW     = 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic signed [DW-1:0] in_x,
  input  logic signed [DW-1:0] in_y,
  input  logic [TW-1:0]        in_tag,
  output logic                 out_valid,
  output logic signed [DW-1:0] out_mag,
  output logic signed [AW-1:0] out_ang,
  output logic [TW-1:0]        out_tag
);

  logic                 v   [0:STAGES];
  logic signed [DW-1:0] xs  [0:STAGES];
  logic signed [DW-1:0] ys  [0:STAGES];
  logic signed [AW-1:0] as_ [0:STAGES];
  logic                 zs  [0:STAGES];
  logic [TW-1:0]        ts  [0:STAGES];

  assign v[0]   = in_valid;
  assign xs[0]  = in_x;
  assign ys[0]  = in_y;
  assign as_[0] = '0;
  assign zs[0]  = (in_x == '0) && (in_y == '0);
  assign ts[0]  = in_tag;

  for (genvar i = 0; i < STAGES; i++) begin : g_cell
    lfaa_cordic_cell #(.IDX(i), .AW(AW), .DW(DW), .TW(TW)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .in_valid (v[i]),
      .in_x     (xs[i]),
      .in_y     (ys[i]),
      .in_a     (as_[i]),
      .in_zero  (zs[i]),
      .in_tag   (ts[i]),
      .out_valid(v[i+1]),
      .out_x    (xs[i+1]),
      .out_y    (ys[i+1]),
      .out_a    (as_[i+1]),
      .out_zero (zs[i+1]),
      .out_tag  (ts[i+1])
    );
  end

  // zero vector gives angle 0
  assign out_valid = v[STAGES];
  assign out_mag   = xs[STAGES];
  assign out_ang   = zs[STAGES] ? '0 : as_[STAGES];
  assign out_tag   = ts[STAGES];

endmodule

[rtl/local_frame_aim_angles_core.sv]
`timescale 1ns / 1ps
// local frame aim angles
// each transaction carries a rigid transform (three packed q1.14 rotation rows
// plus a q15.8 origin) and a q15.8 world target; the block returns the yaw, in
// q2.12 radians, and pitch, q1.12 radians, of the target in the local frame
// input channel: a transaction is taken at a rising edge with start high and
// busy low; busy is held low, so a new transaction may enter every cycle
// output channel: done is high for exactly one cycle with yaw and pitch valid;
// the receiver cannot hold results off, and results leave in input order
// throughput: one transaction per cycle, set by the fully pipelined datapath:
// a six-stage front end (subtract, multiply, sum, magnitude or, msb search,
// normalize), two parallel rows of cordic cells for yaw and the horizontal
// magnitude, one gain multiply, one more row of cells for pitch, one output
// register
// reset clears every valid flag in the pipe; in-flight transactions are dropped
module local_frame_aim_angles_core #(
  parameter int CORDIC_STAGES = 14,
  parameter int COORD_WIDTH   = 24,
  parameter int ANGLE_WIDTH   = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [47:0]                   rot_row0,
  input  logic [47:0]                   rot_row1,
  input  logic [47:0]                   rot_row2,
  input  logic signed [COORD_WIDTH-1:0] origin_x,
  input  logic signed [COORD_WIDTH-1:0] origin_y,
  input  logic signed [COORD_WIDTH-1:0] origin_z,
  input  logic signed [COORD_WIDTH-1:0] target_x,
  input  logic signed [COORD_WIDTH-1:0] target_y,
  input  logic signed [COORD_WIDTH-1:0] target_z,
  input  logic                          need_pitch,
  output logic                          done,
  output logic signed [14:0]            yaw,
  output logic signed [13:0]            pitch
);
  import lfaa_pkg::*;

  localparam int DLW = COORD_WIDTH + 1;          // difference
  localparam int PW  = DLW + ENTRY_BITS;         // one product
  localparam int LW  = PW + 2;                   // local component
  localparam int PB  = $clog2(LW);               // msb position
  localparam int DW  = CORDIC_W;
  localparam int AW  = ANGLE_WIDTH;
  localparam int SH  = ANGLE_WIDTH - 16;         // accumulator frac minus 12
  localparam int RS  = (SH > 0) ? SH : 0;
  localparam int LS  = (SH < 0) ? -SH : 0;
  localparam logic [AW:0] RHALF = (SH > 0) ? (AW+1)'(1) << (RS - 1) : '0;
  localparam logic [PB-1:0] TOPB = PB'(NORM_TOP - 1);
  localparam int TW1 = $bits(yaw_flags_t);
  localparam int TW2 = 16;

  // angle accumulator to q3.12, half away from zero
  function automatic logic signed [Q_W-1:0] to_q12(input logic signed [AW-1:0] a);
    logic [AW:0] m;
    logic [AW:0] r;
    logic signed [Q_W-1:0] s;
    begin
      m = a[AW-1] ? (AW+1)'(-$signed({a[AW-1], a})) : (AW+1)'({1'b0, a});
      r = (m + RHALF) >> RS;
      s = a[AW-1] ? -$signed(Q_W'(r)) : $signed(Q_W'(r));
      return s <<< LS;
    end
  endfunction

  // scale so the common msb lands at NORM_TOP-1, magnitudes truncated
  function automatic logic signed [DW-1:0] norm_val(input logic signed [LW-1:0] v,
                                                    input logic [PB-1:0] p);
    logic [LW-1:0] m;
    logic [LW-1:0] s;
    begin
      m = v[LW-1] ? LW'(-v) : LW'(v);
      if (p >= TOPB) begin
        s = m >> (p - TOPB);
      end else begin
        s = m << (TOPB - p);
      end
      return v[LW-1] ? -$signed(DW'(s)) : $signed(DW'(s));
    end
  endfunction

  function automatic logic [PB-1:0] msb_pos(input logic [LW-1:0] v);
    logic [PB-1:0] p;
    begin
      p = '0;
      for (int i = 0; i < LW; i++) begin
        if (v[i]) begin
          p = PB'(i);
        end
      end
      return p;
    end
  endfunction

  assign busy = 1'b0;

  // stage 1: differences and rotation entries
  logic                   v1, need1;
  logic signed [DLW-1:0]  d1 [0:2];
  logic signed [15:0]     r1 [0:8];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    d1[0] <= DLW'(target_x) - DLW'(origin_x);
    d1[1] <= DLW'(target_y) - DLW'(origin_y);
    d1[2] <= DLW'(target_z) - DLW'(origin_z);
    for (int c = 0; c < 3; c++) begin
      r1[c]   <= $signed(rot_row0[ENTRY_BITS*c +: ENTRY_BITS]);
      r1[3+c] <= $signed(rot_row1[ENTRY_BITS*c +: ENTRY_BITS]);
      r1[6+c] <= $signed(rot_row2[ENTRY_BITS*c +: ENTRY_BITS]);
    end
    need1 <= need_pitch;
  end

  // stage 2: nine products
  logic                  v2, need2;
  logic signed [PW-1:0]  p2 [0:8];

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        p2[3*r+c] <= PW'(r1[3*r+c]) * PW'(d1[c]);
      end
    end
    need2 <= need1;
  end

  // stage 3: local vector as row dot products
  logic                  v3, need3;
  logic signed [LW-1:0]  x3, y3, z3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    x3    <= LW'(p2[0]) + LW'(p2[1]) + LW'(p2[2]);
    y3    <= LW'(p2[3]) + LW'(p2[4]) + LW'(p2[5]);
    z3    <= LW'(p2[6]) + LW'(p2[7]) + LW'(p2[8]);
    need3 <= need2;
  end

  // stage 4: or of magnitudes has the same msb as the largest magnitude
  logic                  v4, need4;
  logic signed [LW-1:0]  x4, y4, z4;
  logic [LW-1:0]         or_yaw4, or_all4;
  logic [LW-1:0]         mx3, my3, mz3;

  assign mx3 = x3[LW-1] ? LW'(-x3) : LW'(x3);
  assign my3 = y3[LW-1] ? LW'(-y3) : LW'(y3);
  assign mz3 = z3[LW-1] ? LW'(-z3) : LW'(z3);

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    x4      <= x3;
    y4      <= y3;
    z4      <= z3;
    or_yaw4 <= mx3 | mz3;
    or_all4 <= mx3 | my3 | mz3;
    need4   <= need3;
  end

  // stage 5: msb search
  logic                  v5, need5;
  logic signed [LW-1:0]  x5, y5, z5;
  logic [PB-1:0]         pos_yaw5, pos_all5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else begin
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    x5       <= x4;
    y5       <= y4;
    z5       <= z4;
    pos_yaw5 <= msb_pos(or_yaw4);
    pos_all5 <= msb_pos(or_all4);
    need5    <= need4;
  end

  // stage 6: normalized vectors and sign flags
  logic                  v6;
  yaw_flags_t            flags6;
  logic signed [DW-1:0]  yx6, yz6, px6, py6, pz6;

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else begin
      v6 <= v5;
    end
  end

  always_ff @(posedge clk) begin
    yx6           <= norm_val(x5, pos_yaw5);
    yz6           <= norm_val(z5, pos_yaw5);
    px6           <= norm_val(x5, pos_all5);
    py6           <= norm_val(y5, pos_all5);
    pz6           <= norm_val(z5, pos_all5);
    flags6.need   <= need5;
    flags6.z_zero <= (z5 == '0);
    flags6.z_neg  <= z5[LW-1];
    flags6.x_pos  <= !x5[LW-1] && (x5 != '0);
    flags6.x_neg  <= x5[LW-1];
  end

  // yaw row and horizontal magnitude row run side by side
  logic                  yv, hv;
  logic signed [DW-1:0]  y_mag, h_mag;
  logic signed [AW-1:0]  y_ang, h_ang;
  logic [TW1-1:0]        y_tag;
  logic [DW-1:0]         h_tag;
  yaw_flags_t            yflags;

  lfaa_cordic_chain #(.STAGES(CORDIC_STAGES), .AW(AW), .DW(DW), .TW(TW1)) u_yaw_row (
    .clk      (clk),
    .rst      (rst),
    .in_valid (v6),
    .in_x     (yz6[DW-1] ? -yz6 : yz6),
    .in_y     (yx6),
    .in_tag   (flags6),
    .out_valid(yv),
    .out_mag  (y_mag),
    .out_ang  (y_ang),
    .out_tag  (y_tag)
  );

  lfaa_cordic_chain #(.STAGES(CORDIC_STAGES), .AW(AW), .DW(DW), .TW(DW)) u_horiz_row (
    .clk      (clk),
    .rst      (rst),
    .in_valid (v6),
    .in_x     (pz6[DW-1] ? -pz6 : pz6),
    .in_y     (px6),
    .in_tag   (py6),
    .out_valid(hv),
    .out_mag  (h_mag),
    .out_ang  (h_ang),
    .out_tag  (h_tag)
  );

  assign yflags = y_tag;

  // yaw finish: quadrant fix, z zero case, clamp to +-pi
  logic signed [Q_W-1:0] yq, yfix;

  always_comb begin
    yq   = to_q12(y_ang);
    yfix = yflags.z_neg ? -yq : yq;
    if (yflags.z_neg && yflags.x_pos) begin
      yfix = yfix + Q_W'(PI_Q12);
    end else if (yflags.z_neg && yflags.x_neg) begin
      yfix = yfix - Q_W'(PI_Q12);
    end
    if (yflags.z_zero) begin
      yfix = yflags.x_pos ? Q_W'(HALF_PI_Q12) : -Q_W'(HALF_PI_Q12);
    end
    if (yfix > Q_W'(PI_Q12)) begin
      yfix = Q_W'(PI_Q12);
    end else if (yfix < -Q_W'(PI_Q12)) begin
      yfix = -Q_W'(PI_Q12);
    end
  end

  // gain stage: horizontal magnitude times 1/K, registered
  logic                       vm, needm;
  logic signed [14:0]         yawm;
  logic [DW+INV_GAIN_W-1:0]   gprod;
  logic signed [DW-1:0]       hm, vym;

  assign gprod = (DW+INV_GAIN_W)'($unsigned(h_mag)) * (DW+INV_GAIN_W)'(INV_GAIN_Q30);

  always_ff @(posedge clk) begin
    if (rst) begin
      vm <= 1'b0;
    end else begin
      vm <= yv;
    end
  end

  always_ff @(posedge clk) begin
    hm    <= $signed(gprod[INV_GAIN_W +: DW]);
    vym   <= $signed(h_tag);
    yawm  <= yfix[14:0];
    needm <= yflags.need;
  end

  // pitch row: elevation of y over the horizontal magnitude
  logic                  pv;
  logic signed [DW-1:0]  p_mag;
  logic signed [AW-1:0]  p_ang;
  logic [TW2-1:0]        p_tag;
  logic                  need_f;
  logic signed [14:0]    yaw_f;

  lfaa_cordic_chain #(.STAGES(CORDIC_STAGES), .AW(AW), .DW(DW), .TW(TW2)) u_pitch_row (
    .clk      (clk),
    .rst      (rst),
    .in_valid (vm),
    .in_x     (hm),
    .in_y     (vym),
    .in_tag   ({needm, yawm}),
    .out_valid(pv),
    .out_mag  (p_mag),
    .out_ang  (p_ang),
    .out_tag  (p_tag)
  );

  assign need_f = p_tag[15];
  assign yaw_f  = $signed(p_tag[14:0]);

  // pitch finish: negate, clamp to +-pi/2, gate by request and yaw range
  logic signed [Q_W-1:0] pq, pfix;
  logic                  use_pitch;

  always_comb begin
    pq   = to_q12(p_ang);
    pfix = -pq;
    if (pfix > Q_W'(HALF_PI_Q12)) begin
      pfix = Q_W'(HALF_PI_Q12);
    end else if (pfix < -Q_W'(HALF_PI_Q12)) begin
      pfix = -Q_W'(HALF_PI_Q12);
    end
    use_pitch = need_f && (yaw_f < 15'sd6434) && (yaw_f > -15'sd6434);
  end

  // output register, one cycle strobe per transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= pv;
    end
  end

  always_ff @(posedge clk) begin
    yaw   <= yaw_f;
    pitch <= use_pitch ? pfix[13:0] : 14'sd0;
  end

  // row outputs that are not needed: yaw and pitch magnitudes, horizontal
  // angle and the horizontal valid, which tracks the yaw valid
  logic unused_mag;
  assign unused_mag = ^{p_mag, y_mag, h_ang, hv};

endmodule
